@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the flash command model.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under the active-low reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/nfep_pkg.sv @@
// Shared types and constants of the NOR flash command model.
package nfep_pkg;

  // Store size default and fixed geometry.
  localparam int unsigned MemBytes  = 65536;
  localparam int unsigned ProgBytes = 16;
  localparam int unsigned ProgAw    = $clog2(ProgBytes);
  localparam int unsigned AddrW     = 32;
  localparam int unsigned SizeW     = 17;
  localparam int unsigned DataW     = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;

  // Register reset values and the erased byte.
  localparam logic [AddrW-1:0] BaseReset   = '0;
  localparam logic [SizeW-1:0] RegionReset = 17'h10000;
  localparam logic [SizeW-1:0] SectorReset = 17'h01000;
  localparam logic [ByteW-1:0] ErasedByte  = 8'hFF;

  typedef enum logic [1:0] {
    CmdRead    = 2'd0,
    CmdErase   = 2'd1,
    CmdProgram = 2'd2,
    CmdPoll    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBusy    = 2'd1,
    StInvalid = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RegBase   = 2'd0,
    RegRegion = 2'd1,
    RegSector = 2'd2
  } reg_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data_low;
    logic [DataW-1:0] data_high;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] read_byte;
  } out_item_t;

  // Status of the serial remainder unit.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_stat_t;

endpackage

@@ rtl/nfep_ram.sv @@
// Generic single-port RAM with registered read data.
module nfep_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read of the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nfep_mod.sv @@
// Serial remainder unit: one dividend bit per cycle, restoring form.
module nfep_mod #(
  parameter int unsigned DVW = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nfep_pkg::AddrW-1:0]    dividend_i,
  input  logic [DVW-1:0]                divisor_i,
  output nfep_pkg::mod_stat_t           stat_o,
  output logic [DVW-1:0]                rem_o
);

  localparam int unsigned Steps = nfep_pkg::AddrW;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [nfep_pkg::AddrW-1:0] dvd_q, dvd_d;
  logic [DVW-1:0]             div_q, div_d;
  logic [DVW-1:0]             rem_q, rem_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic [DVW:0]               trial;
  logic [DVW:0]               diff;
  logic                       take;

  // Shift in the next dividend bit and subtract when it fits.
  assign trial = {rem_q, dvd_q[nfep_pkg::AddrW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign take  = (trial >= {1'b0, div_q});

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
      cnt_d = CntW'(Steps);
    end else if (cnt_q != '0) begin
      rem_d  = take ? diff[DVW-1:0] : trial[DVW-1:0];
      dvd_d  = {dvd_q[nfep_pkg::AddrW-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  // Step counter and done pulse are control; operands are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rem_o           = rem_q;
  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

@@ rtl/nor_flash_erase_program_model_core.sv @@
// Read: decode, store read issue and read data lead to the result beat; the remainder unit finds the index first
// when MEM_BYTES is no power of two. Program: 16 read-compare pairs on the single store RAM port.
// Erase request: checked by the 32-step serial remainder unit (address mod sector).
// Executing poll: one store byte written per cycle, 16 or sector_bytes of them.
// One item is in work at a time; the next is taken once the result is registered.
// Reset clears control state, then a pass writes 0xFF to all MEM_BYTES entries, one per cycle.
module nor_flash_erase_program_model_core #(
  parameter int unsigned MEM_BYTES = nfep_pkg::MemBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nfep_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nfep_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfep_pkg::PaddrW-1:0]   paddr,
  input  logic [nfep_pkg::PdataW-1:0]   pwdata,
  output logic [nfep_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned MemAw   = $clog2(MEM_BYTES);
  localparam int unsigned MemDw   = $clog2(MEM_BYTES + 1);
  localparam int unsigned DvW     = (nfep_pkg::SizeW > MemDw) ? nfep_pkg::SizeW : MemDw;
  localparam bit          MemPow2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
  localparam logic [MemAw-1:0] IdxLast = MemAw'(MEM_BYTES - 1);
  localparam int unsigned AW = nfep_pkg::AddrW;
  localparam int unsigned SW = nfep_pkg::SizeW;
  localparam int unsigned PA = nfep_pkg::ProgAw;
  localparam logic [SW-1:0] ProgLen  = SW'(nfep_pkg::ProgBytes);
  localparam logic [SW-1:0] ProgLast = SW'(nfep_pkg::ProgBytes - 1);

  typedef enum logic [9:0] {
    SClear     = 10'b0000000001,
    SIdle      = 10'b0000000010,
    SDecode    = 10'b0000000100,
    SModWait   = 10'b0000001000,
    SReadIssue = 10'b0000010000,
    SReadData  = 10'b0000100000,
    SChkIssue  = 10'b0001000000,
    SChkCmp    = 10'b0010000000,
    SWrite     = 10'b0100000000,
    SResp      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [AW-1:0] base_q, base_d;
  logic [SW-1:0] region_q, region_d;
  logic [SW-1:0] sector_q, sector_d;

  // Request state.
  logic          pending_q, pending_d;
  logic          executing_q, executing_d;
  logic          pend_prog_q, pend_prog_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic [2*nfep_pkg::DataW-1:0] pend_word_q, pend_word_d;

  // Captured item and sequencer working registers.
  nfep_pkg::cmd_e cmd_q, cmd_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic [2*nfep_pkg::DataW-1:0] word_q, word_d;
  logic [MemAw-1:0] idx_q, idx_d;
  logic [SW-1:0]    cnt_q, cnt_d;
  logic             bad_q, bad_d;
  nfep_pkg::status_e res_status_q, res_status_d;
  logic [nfep_pkg::ByteW-1:0] res_byte_q, res_byte_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  nfep_pkg::out_item_t out_data_q, out_data_d;

  // Datapath signals.
  logic [AW-1:0]    off;
  logic [AW-1:0]    poll_off;
  logic [AW-1:0]    idx_src;
  logic [SW-1:0]    room;
  logic             off_ok, in1, in16, in_sec, busy;
  logic [MemAw-1:0] idx_inc;
  logic [SW-1:0]    wr_len;
  logic [nfep_pkg::ByteW-1:0] chk_new, pend_byte;
  logic             chk_bad;
  state_e           after_st;
  logic             need_idx;

  logic                     mod_start;
  logic [AW-1:0]            mod_dvd;
  logic [DvW-1:0]           mod_div;
  logic [DvW-1:0]           mod_rem;
  nfep_pkg::mod_stat_t      mod_stat;

  logic                       ram_we;
  logic [nfep_pkg::ByteW-1:0] ram_wdata;
  logic [nfep_pkg::ByteW-1:0] ram_rdata;

  // Range test against the region, for one, sixteen and sector_bytes bytes.
  assign off    = addr_q - base_q;
  assign off_ok = (addr_q >= base_q) && (off <= {{(AW-SW){1'b0}}, region_q});
  assign room   = region_q - off[SW-1:0];
  assign in1    = off_ok && (room != '0);
  assign in16   = off_ok && (room >= ProgLen);
  assign in_sec = off_ok && (room >= sector_q);
  assign busy   = pending_q | executing_q;

  // Store offset sources and the remainder unit operands.
  assign poll_off = pend_addr_q - base_q;
  assign idx_src  = (cmd_q == nfep_pkg::CmdPoll) ? poll_off : off;
  assign mod_dvd  = (cmd_q == nfep_pkg::CmdErase) ? addr_q : idx_src;
  assign mod_div  = (cmd_q == nfep_pkg::CmdErase) ? DvW'(sector_q) : DvW'(MEM_BYTES);

  // Store index steps with wrap at the end of the store.
  assign idx_inc = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;

  // Byte selection for the program check and the program write.
  assign chk_new   = word_q[{cnt_q[PA-1:0], 3'b000} +: nfep_pkg::ByteW];
  assign pend_byte = pend_word_q[{cnt_q[PA-1:0], 3'b000} +: nfep_pkg::ByteW];
  assign chk_bad   = bad_q | ((ram_rdata & chk_new) != chk_new);
  assign wr_len    = pend_prog_q ? ProgLen : sector_q;

  // Where a command goes once its store index is known.
  always_comb begin
    case (cmd_q)
      nfep_pkg::CmdRead:    after_st = SReadIssue;
      nfep_pkg::CmdProgram: after_st = SChkIssue;
      default:              after_st = SWrite;
    endcase
  end

  // Command sequencer.
  always_comb begin
    state_d      = state_q;
    pending_d    = pending_q;
    executing_d  = executing_q;
    pend_prog_d  = pend_prog_q;
    pend_addr_d  = pend_addr_q;
    pend_word_d  = pend_word_q;
    cmd_d        = cmd_q;
    addr_d       = addr_q;
    word_d       = word_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    bad_d        = bad_q;
    res_status_d = res_status_q;
    res_byte_d   = res_byte_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    mod_start    = 1'b0;
    need_idx     = 1'b0;

    // A taken result beat frees the output register.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SClear: begin
        idx_d = idx_inc;
        if (idx_q == IdxLast) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          addr_d  = in_data_i.address;
          word_d  = {in_data_i.data_high, in_data_i.data_low};
          state_d = SDecode;
        end
      end
      SDecode: begin
        cnt_d        = '0;
        bad_d        = 1'b0;
        res_byte_d   = '0;
        res_status_d = nfep_pkg::StOk;
        state_d      = SResp;
        case (cmd_q)
          nfep_pkg::CmdRead: begin
            if (!in1) begin
              res_status_d = nfep_pkg::StInvalid;
            end else if (busy) begin
              res_status_d = nfep_pkg::StBusy;
            end else begin
              need_idx = 1'b1;
            end
          end
          nfep_pkg::CmdErase: begin
            if (busy) begin
              res_status_d = nfep_pkg::StBusy;
            end else if (sector_q == '0 || !in_sec) begin
              res_status_d = nfep_pkg::StInvalid;
            end else begin
              mod_start = 1'b1;
              state_d   = SModWait;
            end
          end
          nfep_pkg::CmdProgram: begin
            if (busy) begin
              res_status_d = nfep_pkg::StBusy;
            end else if (addr_q[PA-1:0] != '0 || !in16) begin
              res_status_d = nfep_pkg::StInvalid;
            end else begin
              need_idx = 1'b1;
            end
          end
          default: begin
            // Poll: start the queued request, or carry it out.
            if (!executing_q) begin
              if (pending_q) begin
                executing_d  = 1'b1;
                res_status_d = nfep_pkg::StBusy;
              end
            end else begin
              need_idx = 1'b1;
            end
          end
        endcase
        if (need_idx) begin
          if (MemPow2) begin
            idx_d   = idx_src[MemAw-1:0];
            state_d = after_st;
          end else begin
            mod_start = 1'b1;
            state_d   = SModWait;
          end
        end
      end
      SModWait: begin
        if (mod_stat.done) begin
          if (cmd_q == nfep_pkg::CmdErase) begin
            state_d = SResp;
            if (mod_stat.rem_zero) begin
              pend_addr_d  = addr_q;
              pend_prog_d  = 1'b0;
              pending_d    = 1'b1;
              res_status_d = nfep_pkg::StOk;
            end else begin
              res_status_d = nfep_pkg::StInvalid;
            end
          end else begin
            idx_d   = mod_rem[MemAw-1:0];
            state_d = after_st;
          end
        end
      end
      SReadIssue: begin
        state_d = SReadData;
      end
      SReadData: begin
        res_byte_d   = ram_rdata;
        res_status_d = nfep_pkg::StOk;
        state_d      = SResp;
      end
      SChkIssue: begin
        state_d = SChkCmp;
      end
      SChkCmp: begin
        // A program may only clear bits of the stored bytes.
        bad_d = chk_bad;
        idx_d = idx_inc;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ProgLast) begin
          state_d = SResp;
          if (chk_bad) begin
            res_status_d = nfep_pkg::StInvalid;
          end else begin
            pend_word_d  = word_q;
            pend_addr_d  = addr_q;
            pend_prog_d  = 1'b1;
            pending_d    = 1'b1;
            res_status_d = nfep_pkg::StOk;
          end
        end else begin
          state_d = SChkIssue;
        end
      end
      SWrite: begin
        if (cnt_q == wr_len) begin
          pending_d    = 1'b0;
          executing_d  = 1'b0;
          res_status_d = nfep_pkg::StOk;
          state_d      = SResp;
        end else begin
          idx_d = idx_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      SResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_data_d.status    = res_status_q;
          out_data_d.read_byte = res_byte_q;
          state_d              = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Store writes come from the clearing pass and the executing poll only.
  assign ram_we    = (state_q == SClear) || ((state_q == SWrite) && (cnt_q != wr_len));
  assign ram_wdata = ((state_q == SWrite) && pend_prog_q) ? pend_byte : nfep_pkg::ErasedByte;

  // Configuration writes.
  always_comb begin
    base_d   = base_q;
    region_d = region_q;
    sector_d = sector_q;
    if (psel && penable && pwrite) begin
      case (nfep_pkg::reg_e'(paddr[3:2]))
        nfep_pkg::RegBase:   base_d   = pwdata;
        nfep_pkg::RegRegion: region_d = pwdata[SW-1:0];
        nfep_pkg::RegSector: sector_d = pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Configuration reads.
  always_comb begin
    case (nfep_pkg::reg_e'(paddr[3:2]))
      nfep_pkg::RegBase:   prdata = base_q;
      nfep_pkg::RegRegion: prdata = {{(nfep_pkg::PdataW-SW){1'b0}}, region_q};
      nfep_pkg::RegSector: prdata = {{(nfep_pkg::PdataW-SW){1'b0}}, sector_q};
      default:             prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      idx_q       <= '0;
      base_q      <= nfep_pkg::BaseReset;
      region_q    <= nfep_pkg::RegionReset;
      sector_q    <= nfep_pkg::SectorReset;
      pending_q   <= 1'b0;
      executing_q <= 1'b0;
      pend_prog_q <= 1'b0;
      pend_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      base_q      <= base_d;
      region_q    <= region_d;
      sector_q    <= sector_d;
      pending_q   <= pending_d;
      executing_q <= executing_d;
      pend_prog_q <= pend_prog_d;
      pend_addr_q <= pend_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_word_q  <= pend_word_d;
    cmd_q        <= cmd_d;
    addr_q       <= addr_d;
    word_q       <= word_d;
    cnt_q        <= cnt_d;
    bad_q        <= bad_d;
    res_status_q <= res_status_d;
    res_byte_q   <= res_byte_d;
    out_data_q   <= out_data_d;
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Shared remainder unit: store index and sector alignment.
  nfep_mod #(
    .DVW (DvW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (mod_div),
    .stat_o     (mod_stat),
    .rem_o      (mod_rem)
  );

  // Byte-wide flash store.
  nfep_ram #(
    .Width (nfep_pkg::ByteW),
    .Depth (MEM_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (idx_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

@@ rtl/nfep_chk.sv @@
// Port-level checker for the flash command model, bound to the top level.
`include "assert_macros.svh"

module nfep_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input nfep_pkg::out_item_t out_data_o
);

  // A stalled result beat stays and holds its payload.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Only an ok read carries a byte.
  `ASSERT_IMP(a_byte_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status != nfep_pkg::StOk), out_data_o.read_byte == 8'h00)

  // One item in work at a time: an accepted beat closes the input side.
  `ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind nor_flash_erase_program_model_core nfep_chk u_nfep_chk (.*);
